// ===== rtl/core/stpc_pkg.sv =====
package stpc_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;

	localparam int KIND_W      = 2;
	localparam int OPERAND_W   = 31;
	localparam int THRESHOLD_W = 63;
	localparam int COUNT_W     = 11;
	localparam int PROD_W      = 2 * OPERAND_W;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [OPERAND_W-1:0] operand;
	} req_t;

endpackage

// ===== rtl/core/sorted_table_product_threshold_count.sv =====
// Sorted table with a product-threshold count. Clear empties the table, load inserts
// its operand in ascending order after equal entries (a load into a full table is
// dropped), and query returns how many stored values v satisfy v*operand >= threshold.
// Only query produces a result. A two-entry request queue decouples the input from the
// table engine, so requests are taken while an earlier one is still running. Query
// runs a binary search; each probe is a memory read, a 31x31 multiply and a compare.
// Load walks down from the top of the table shifting larger entries up one slot.
// Write threshold only while idle.
module sorted_table_product_threshold_count #(
	parameter int TABLE_DEPTH = stpc_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [stpc_pkg::THRESHOLD_W-1:0]  wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [stpc_pkg::KIND_W-1:0]       kind,
	input  logic [stpc_pkg::OPERAND_W-1:0]    operand,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [stpc_pkg::COUNT_W-1:0]      match_count
);
	import stpc_pkg::*;

	req_t req;
	logic req_valid;
	logic req_pop;

	stpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.operand   (operand),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop)
	);

	stpc_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_data     (wr_data),
		.req_valid   (req_valid),
		.req         (req),
		.req_pop     (req_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.match_count (match_count)
	);

endmodule

// ===== rtl/core/stpc_front.sv =====
module stpc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [stpc_pkg::KIND_W-1:0]       kind,
	input  logic [stpc_pkg::OPERAND_W-1:0]    operand,
	output logic                              req_valid,
	output stpc_pkg::req_t                    req,
	input  logic                              req_pop
);
	import stpc_pkg::*;

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	req_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              keep;
	logic              push;
	logic              pop;

	always_comb begin
		keep = kind inside {KIND_CLEAR, KIND_LOAD, KIND_QUERY};
	end

	assign in_stall  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall && keep;
	assign req_valid = (cnt_q != '0);
	assign pop       = req_pop && req_valid;
	assign req       = queue_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{kind: kind, operand: operand};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/stpc_back.sv =====
module stpc_back #(
	parameter int TABLE_DEPTH = stpc_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [stpc_pkg::THRESHOLD_W-1:0]  wr_data,
	input  logic                              req_valid,
	input  stpc_pkg::req_t                    req,
	output logic                              req_pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [stpc_pkg::COUNT_W-1:0]      match_count
);
	import stpc_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LD_RD  = 3'd1;
	localparam logic [2:0] ST_LD_CMP = 3'd2;
	localparam logic [2:0] ST_Q_CHK  = 3'd3;
	localparam logic [2:0] ST_Q_MUL  = 3'd4;
	localparam logic [2:0] ST_Q_CMP  = 3'd5;

	logic [OPERAND_W-1:0]   mem [TABLE_DEPTH];
	logic [OPERAND_W-1:0]   rd_data_q;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [OPERAND_W-1:0]   mem_wdata;
	logic [AW-1:0]          mem_raddr;

	logic [2:0]             state_q;
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          lo_q;
	logic [CW-1:0]          hi_q;
	logic [CW-1:0]          mid_q;
	logic [CW-1:0]          mid;
	logic [OPERAND_W-1:0]   opnd_q;
	logic [PROD_W-1:0]      prod_q;
	logic [THRESHOLD_W-1:0] thr_q;
	logic                   out_valid_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   out_free;
	logic                   q_done;

	assign out_valid   = out_valid_q;
	assign match_count = count_q;
	assign out_free    = !out_valid_q || !out_stall;
	assign req_pop     = (state_q == ST_IDLE) && req_valid;
	assign mid         = lo_q + ((hi_q - lo_q) >> 1);
	assign q_done      = (state_q == ST_Q_CHK) && !(lo_q < hi_q) && out_free;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = opnd_q;
		mem_raddr = mid[AW-1:0];
		case (state_q)
			ST_LD_RD: begin
				mem_raddr = AW'(idx_q - 1'b1);
				if (idx_q == '0) begin
					mem_we = 1'b1;
				end
			end
			ST_LD_CMP: begin
				mem_we = 1'b1;
				if (rd_data_q > opnd_q) begin
					mem_wdata = rd_data_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_Q_MUL) begin
			prod_q <= PROD_W'(rd_data_q) * PROD_W'(opnd_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (wr_en) begin
			thr_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			opnd_q      <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (q_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						opnd_q <= req.operand;
						case (req.kind)
							KIND_CLEAR: begin
								fill_q <= '0;
							end
							KIND_LOAD: begin
								if (fill_q != CW'(TABLE_DEPTH)) begin
									idx_q   <= fill_q;
									state_q <= ST_LD_RD;
								end
							end
							KIND_QUERY: begin
								lo_q    <= '0;
								hi_q    <= fill_q;
								state_q <= ST_Q_CHK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LD_RD: begin
					if (idx_q == '0) begin
						fill_q  <= fill_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LD_CMP;
					end
				end
				ST_LD_CMP: begin
					if (rd_data_q > opnd_q) begin
						idx_q   <= idx_q - 1'b1;
						state_q <= ST_LD_RD;
					end else begin
						fill_q  <= fill_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_Q_CHK: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_Q_MUL;
					end else if (out_free) begin
						count_q <= COUNT_W'(fill_q - lo_q);
						state_q <= ST_IDLE;
					end
				end
				ST_Q_MUL: begin
					state_q <= ST_Q_CMP;
				end
				ST_Q_CMP: begin
					if ({1'b0, prod_q} >= thr_q) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q + 1'b1;
					end
					state_q <= ST_Q_CHK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill level beyond table depth");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_MUL || state_q == ST_Q_CMP) |-> (mid_q < hi_q && lo_q <= mid_q))
		else $error("search probe outside the live window");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_CHK || state_q == ST_Q_MUL || state_q == ST_Q_CMP)
		|-> (lo_q <= hi_q && hi_q <= fill_q))
		else $error("search window inverted");

	a_load_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD_RD && idx_q == '0) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("load finished without growing the table");

	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_CHK && lo_q >= hi_q && !out_valid_q)
		|=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished query produced no result");

endmodule

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stpc_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int RANDOM_ITEMS = 600;
	localparam logic [THRESHOLD_W-1:0] MAX_PRODUCT =
		THRESHOLD_W'(31'h7fff_ffff) * THRESHOLD_W'(31'h7fff_ffff);

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   wr_en     = 1'b0;
	logic [THRESHOLD_W-1:0] wr_data   = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic [KIND_W-1:0]      kind      = KIND_CLEAR;
	logic [OPERAND_W-1:0]   operand   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [COUNT_W-1:0]     match_count;

	// requests waiting for the driver, and the model of the table
	req_t                   pending_reqs[$];
	logic [OPERAND_W-1:0]   stored_values[$];
	logic [THRESHOLD_W-1:0] threshold_value;
	logic [COUNT_W-1:0]     due_counts[$];

	int                     items_sent;
	int                     mismatches;
	int                     cycle_count;
	int                     burst_left;
	int                     gap_left;
	int                     stall_mode;
	int                     stall_left;
	req_t                   next_req;
	logic [COUNT_W-1:0]     want_count;

	sorted_table_product_threshold_count u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.operand    (operand),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.match_count(match_count)
	);

	always #5ns clk = ~clk;

	// Update the table model with one accepted request; a query yields the count it is due.
	function automatic void apply_request(req_t r);
		int          pos;
		int          hits;
		logic [61:0] prod;
		case (r.kind)
			KIND_CLEAR: stored_values.delete();
			KIND_LOAD: if (stored_values.size() < TABLE_DEPTH_DEF) begin
				pos = stored_values.size();
				while (pos > 0 && stored_values[pos-1] > r.operand)
					pos--;
				stored_values.insert(pos, r.operand);
			end
			KIND_QUERY: begin
				hits = 0;
				foreach (stored_values[i]) begin
					prod = 62'(stored_values[i]) * 62'(r.operand);
					if ({1'b0, prod} >= threshold_value)
						hits++;
				end
				due_counts.insert(due_counts.size(), COUNT_W'(hits));
			end
			default: ;
		endcase
	endfunction

	function automatic void push_req(logic [KIND_W-1:0] k, logic [OPERAND_W-1:0] v);
		req_t r;
		r.kind = k;
		r.operand = v;
		pending_reqs.insert(pending_reqs.size(), r);
		if (k != KIND_UNUSED)
			items_sent++;
	endfunction

	function automatic logic [OPERAND_W-1:0] pick_operand(int w);
		logic [OPERAND_W-1:0] mask;
		int                   sel;
		mask = 31'h7fff_ffff >> (OPERAND_W - w);
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return mask;
		return OPERAND_W'($urandom) & mask;
	endfunction

	function automatic logic [THRESHOLD_W-1:0] pick_threshold(int vw, int mw);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return THRESHOLD_W'({$urandom, $urandom});
			default: return THRESHOLD_W'(pick_operand(vw)) * THRESHOLD_W'(pick_operand(mw));
		endcase
	endfunction

	// Hold until every request is taken and every count has come, then let trailing loads finish.
	task automatic drain_requests();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || due_counts.size() != 0);
		repeat (3 * (2 * stored_values.size() + 36) + 40) @(posedge clk);
		while (due_counts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(logic [THRESHOLD_W-1:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		threshold_value = value;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_CLEAR;
			operand <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				apply_request(req_t'({kind, operand}));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					next_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					kind <= next_req.kind;
					operand <= next_req.operand;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode = 0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_counts.size() == 0) begin
					$display("%0t: match_count expected none actual %0d", $time, match_count);
					mismatches++;
				end else begin
					want_count = due_counts.pop_front();
					if (match_count !== want_count) begin
						$display("%0t: match_count expected %0d actual %0d",
							$time, want_count, match_count);
						mismatches++;
					end
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		logic [OPERAND_W-1:0] fill_value;
		int                   vw;
		int                   mw;
		int                   sel;
		int                   planned_fill;
		threshold_value = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, extremes, duplicates, unused kind, threshold corners
		push_req(KIND_QUERY, '0);
		push_req(KIND_LOAD, '0);
		push_req(KIND_LOAD, '1);
		push_req(KIND_LOAD, 31'd5);
		push_req(KIND_LOAD, 31'd5);
		push_req(KIND_LOAD, 31'd1);
		push_req(KIND_QUERY, '0);
		push_req(KIND_QUERY, '1);
		push_req(KIND_UNUSED, '1);
		push_req(KIND_QUERY, 31'd2);
		drain_requests();
		write_threshold(MAX_PRODUCT);
		push_req(KIND_QUERY, '1);
		push_req(KIND_QUERY, 31'h7fff_fffe);
		push_req(KIND_QUERY, '0);
		drain_requests();
		write_threshold('1);
		push_req(KIND_QUERY, '1);
		drain_requests();
		write_threshold(63'd10);
		push_req(KIND_QUERY, 31'd2);
		push_req(KIND_QUERY, '0);
		push_req(KIND_QUERY, 31'd1);
		push_req(KIND_CLEAR, '1);
		push_req(KIND_QUERY, '1);

		// fill to capacity in ascending order, then load into the full table
		drain_requests();
		write_threshold('0);
		push_req(KIND_CLEAR, '0);
		fill_value = '0;
		for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
			if (i == 0 || $urandom_range(0, 7) != 0)
				fill_value = OPERAND_W'(i << 21) | OPERAND_W'($urandom_range(0, (1 << 21) - 1));
			push_req(KIND_LOAD, fill_value);
		end
		push_req(KIND_QUERY, '0);
		push_req(KIND_LOAD, '0);
		push_req(KIND_QUERY, '1);
		drain_requests();
		write_threshold(pick_threshold(31, 31));
		repeat (8) push_req(KIND_QUERY, pick_operand($urandom_range(1, 31)));
		push_req(KIND_CLEAR, '0);

		// random segments at varied operand widths
		items_sent = 0;
		planned_fill = 0;
		while (items_sent < RANDOM_ITEMS) begin
			vw = ($urandom_range(0, 3) == 0) ? OPERAND_W : $urandom_range(1, OPERAND_W);
			mw = ($urandom_range(0, 3) == 0) ? OPERAND_W : $urandom_range(1, OPERAND_W);
			if ($urandom_range(0, 3) == 0) begin
				drain_requests();
				write_threshold(pick_threshold(vw, mw));
			end else if ($urandom_range(0, 7) == 0) begin
				drain_requests();
			end
			if (planned_fill > 150 || $urandom_range(0, 3) != 0) begin
				push_req(KIND_CLEAR, pick_operand(OPERAND_W));
				planned_fill = 0;
			end
			repeat ($urandom_range(4, 40)) begin
				sel = $urandom_range(0, 19);
				if (sel < 9) begin
					push_req(KIND_LOAD, pick_operand(vw));
					planned_fill++;
				end else if (sel < 18) begin
					push_req(KIND_QUERY, pick_operand(mw));
				end else if (sel == 18) begin
					push_req(KIND_CLEAR, pick_operand(OPERAND_W));
					planned_fill = 0;
				end else begin
					push_req(KIND_UNUSED, pick_operand(OPERAND_W));
				end
			end
		end

		drain_requests();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sorted_table_product_threshold_count.f =====
rtl/core/stpc_pkg.sv
rtl/core/stpc_front.sv
rtl/core/stpc_back.sv
rtl/core/sorted_table_product_threshold_count.sv
dv/tb.sv
